@@ rtl/ocs_pkg.sv @@
package ocs_pkg;

    localparam int KIND_W    = 2;
    localparam int ID_W      = 32;
    localparam int OUT_CNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [ID_W-1:0] CONTROL_CHANNEL = 32'd0;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_status;

endpackage

@@ rtl/ocs_ctrl.sv @@
module ocs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output ocs_pkg::t_cmd   o_cmd,
    input  ocs_pkg::t_status i_status
);
    import ocs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ rtl/ocs_datapath.sv @@
module ocs_datapath #(
    parameter int MAX_OPEN = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ocs_pkg::t_cmd                      i_cmd,
    output ocs_pkg::t_status                   o_status,
    input  logic [ocs_pkg::KIND_W-1:0]         i_kind,
    input  logic [ocs_pkg::ID_W-1:0]           i_channel_id,
    output logic                               o_done,
    output logic                               o_ok,
    output logic [ocs_pkg::OUT_CNT_W-1:0]      o_open_count
);
    import ocs_pkg::*;

    localparam int IDX_W = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
    localparam int CNT_W = $clog2(MAX_OPEN + 1);

    logic [ID_W-1:0]     r_mem [0:MAX_OPEN-1];
    logic [MAX_OPEN-1:0] r_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic [KIND_W-1:0]   r_kind;
    logic [ID_W-1:0]     r_id;
    logic [IDX_W-1:0]    r_idx;

    logic [ID_W-1:0]     r_rd_data;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_cmp_go;

    logic                r_found;
    logic [IDX_W-1:0]    r_found_idx;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;

    logic                r_done;
    logic                r_ok;
    logic [OUT_CNT_W-1:0] r_out_cnt;

    logic                n_ok;
    logic                do_open;
    logic                do_close;

    assign o_status.scan_last = (r_idx == IDX_W'(MAX_OPEN - 1));

    // result of the item at commit
    always_comb begin
        n_ok     = 1'b0;
        do_open  = 1'b0;
        do_close = 1'b0;
        n_count  = r_count;
        case (r_kind)
            KIND_OPEN: begin
                do_open = (r_id != CONTROL_CHANNEL) && (r_count < CNT_W'(MAX_OPEN))
                          && !r_found && r_free_found;
                n_ok    = do_open;
                if (do_open) begin
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            KIND_CLOSE: begin
                do_close = r_found;
                n_ok     = r_found;
                if (r_found) begin
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            KIND_QUERY: begin
                n_ok = r_found;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // id memory: one read per scan cycle, one write at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_open) begin
            r_mem[r_free_idx] <= r_id;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_id   <= i_channel_id;
        end
        r_rd_vld <= r_valid[r_idx];
        r_rd_idx <= r_idx;
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.scan && !o_status.scan_last) begin
            r_idx <= IDX_W'(r_idx + 1'b1);
        end
        if (i_cmd.load) begin
            r_found_idx <= '0;
            r_free_idx  <= '0;
        end else begin
            if (r_cmp_go && r_rd_vld && (r_rd_data == r_id) && !r_found) begin
                r_found_idx <= r_rd_idx;
            end
            if (i_cmd.scan && !r_valid[r_idx] && !r_free_found) begin
                r_free_idx <= r_idx;
            end
        end
        r_ok      <= n_ok;
        r_out_cnt <= OUT_CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_count      <= '0;
            r_cmp_go     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_cmp_go <= i_cmd.scan;
            r_done   <= i_cmd.commit;
            if (i_cmd.load) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (r_cmp_go && r_rd_vld && (r_rd_data == r_id)) begin
                    r_found <= 1'b1;
                end
                if (i_cmd.scan && !r_valid[r_idx]) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
                if (do_open) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
                if (do_close) begin
                    r_valid[r_found_idx] <= 1'b0;
                end
            end
        end
    end

    assign o_done       = r_done;
    assign o_ok         = r_ok;
    assign o_open_count = r_out_cnt;

endmodule

@@ rtl/open_channel_set_unit.sv @@
// a new item is taken only while the unit is idle (busy low); the slot scan reads
//   one entry of the id memory per cycle, then the drain state ends the last compare
//   and the commit state updates the set; o_done is registered from the commit state
// reset: synchronous, clears valid bits, open count and control; id memory is not cleared
// results are shown for one cycle under o_done; the receiver cannot stall
module open_channel_set_unit #(
    parameter int MAX_OPEN = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ocs_pkg::KIND_W-1:0]    i_kind,
    input  logic [ocs_pkg::ID_W-1:0]      i_channel_id,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [ocs_pkg::OUT_CNT_W-1:0] o_open_count
);
    import ocs_pkg::*;

    t_cmd    cmd;
    t_status status;

    ocs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    ocs_datapath #(
        .MAX_OPEN (MAX_OPEN)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_channel_id (i_channel_id),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_open_count (o_open_count)
    );

endmodule

@@ rtl/ocs_checker.sv @@
module ocs_checker #(
    parameter int MAX_OPEN = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [ocs_pkg::OUT_CNT_W-1:0] o_open_count
);
    import ocs_pkg::*;

    // accepted transfer keeps the unit busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start transfer");

    // result strobe only once the unit is free again
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("o_done while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("o_done held for more than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_open_count) <= 32'(MAX_OPEN)))
        else $error("open count above capacity");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done)
        else $error("unit not idle after reset");

endmodule

bind open_channel_set_unit ocs_checker #(
    .MAX_OPEN (MAX_OPEN)
) u_ocs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_open_count (o_open_count)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ocs_pkg::*;

    localparam int MAX_OPEN = 16;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ITEMS = 1025;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic                 ok;
        logic [OUT_CNT_W-1:0] open_count;
    } t_set_result;

    class channel_set_scoreboard;
        logic [ID_W-1:0] slot_id [MAX_OPEN];
        bit              slot_used [MAX_OPEN];
        int unsigned     open_total;
        t_set_result     pending_results [$];
        int unsigned     mismatches;

        function int find_open(logic [ID_W-1:0] id);
            for (int i = 0; i < MAX_OPEN; i++) begin
                if (slot_used[i] && slot_id[i] == id)
                    return i;
            end
            return -1;
        endfunction

        // predict the result of one accepted command and update the set
        function void note_command(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
            t_set_result res;
            int          hit;
            int          free_slot;
            hit = find_open(id);
            res.ok = 1'b0;
            case (kind)
                KIND_OPEN: begin
                    if (id != CONTROL_CHANNEL && open_total < MAX_OPEN && hit < 0) begin
                        free_slot = -1;
                        // lowest free slot
                        for (int i = MAX_OPEN - 1; i >= 0; i--) begin
                            if (!slot_used[i])
                                free_slot = i;
                        end
                        if (free_slot >= 0) begin
                            slot_id[free_slot] = id;
                            slot_used[free_slot] = 1'b1;
                            open_total++;
                            res.ok = 1'b1;
                        end
                    end
                end
                KIND_CLOSE: begin
                    if (hit >= 0) begin
                        slot_used[hit] = 1'b0;
                        if (open_total > 0)
                            open_total--;
                        res.ok = 1'b1;
                    end
                end
                KIND_QUERY: begin
                    res.ok = (hit >= 0);
                end
                default: begin
                    res.ok = 1'b0;
                end
            endcase
            res.open_count = open_total[OUT_CNT_W-1:0];
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(logic ok, logic [OUT_CNT_W-1:0] open_count);
            t_set_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: ok %0d open_count %0d", ok, open_count);
                return;
            end
            want = pending_results.pop_front();
            if (ok !== want.ok) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch on ok: expected %0d actual %0d", want.ok, ok);
            end
            if (open_count !== want.open_count) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch on open_count: expected %0d actual %0d",
                        want.open_count, open_count);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind;
    logic [ID_W-1:0]      i_channel_id;
    logic                 o_done;
    logic                 o_ok;
    logic [OUT_CNT_W-1:0] o_open_count;

    channel_set_scoreboard sb;
    logic [ID_W-1:0]       id_pool [POOL_SIZE];
    int                    item_count;
    int                    pick;
    logic [KIND_W-1:0]     rand_kind;
    logic [ID_W-1:0]       rand_id;

    open_channel_set_unit #(
        .MAX_OPEN(MAX_OPEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_channel_id(i_channel_id),
        .o_done(o_done),
        .o_ok(o_ok),
        .o_open_count(o_open_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_ok, o_open_count);
    end

    // stretches of back-to-back commands between randomly spaced ones
    function int next_gap(int n);
        if ((n / 64) % 3 == 2)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // idle cycles are counted once the unit is free again
    task automatic send_command(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
        int gap;
        gap = next_gap(item_count);
        if (gap != 0) begin
            start <= 1'b0;
            @(posedge i_clk);
            while (busy)
                @(posedge i_clk);
            repeat (gap - 1) @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_channel_id <= id;
        do @(posedge i_clk); while (busy);
        sb.note_command(kind, id);
        item_count++;
    endtask

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        sb = new;
        item_count = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_kind <= KIND_QUERY;
        i_channel_id <= CONTROL_CHANNEL;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty set, control channel, duplicates, unused kind
        send_command(KIND_QUERY, 32'd1);
        send_command(KIND_OPEN, CONTROL_CHANNEL);
        send_command(KIND_CLOSE, CONTROL_CHANNEL);
        send_command(KIND_QUERY, CONTROL_CHANNEL);
        send_command(KIND_OPEN, 32'hFFFF_FFFF);
        send_command(KIND_OPEN, 32'hFFFF_FFFF);
        send_command(KIND_UNUSED, 32'hFFFF_FFFF);
        send_command(KIND_CLOSE, 32'd5);
        send_command(KIND_QUERY, 32'hFFFF_FFFF);
        // fill the set, then overflow it
        for (int k = 0; k < MAX_OPEN - 1; k++)
            send_command(KIND_OPEN, 32'd1 << k);
        send_command(KIND_OPEN, 32'hA5A5_A5A5);
        send_command(KIND_CLOSE, 32'hFFFF_FFFF);

        for (int k = 0; k < POOL_SIZE; k++) begin
            if (k < MAX_OPEN - 1)
                id_pool[k] = 32'd1 << k;
            else if (k == MAX_OPEN - 1)
                id_pool[k] = 32'hFFFF_FFFF;
            else
                id_pool[k] = $urandom | 32'd1;
        end

        // alternate open-heavy and close-heavy stretches so the set fills and drains
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if ((n / 120) % 2 == 0)
                rand_kind = (pick < 60) ? KIND_OPEN : (pick < 80) ? KIND_CLOSE :
                            (pick < 95) ? KIND_QUERY : KIND_UNUSED;
            else
                rand_kind = (pick < 25) ? KIND_OPEN : (pick < 80) ? KIND_CLOSE :
                            (pick < 95) ? KIND_QUERY : KIND_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 84)
                rand_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 95)
                rand_id = $urandom;
            else
                rand_id = CONTROL_CHANNEL;
            send_command(rand_kind, rand_id);
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (MAX_OPEN + 8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            if (sb.pending() != 0)
                $display("%0d results never arrived", sb.pending());
            $display("testbench failed");
        end
        $finish;
    end

endmodule
